// ===== sv/mep_pkg.sv =====
package mep_pkg;

    localparam int DATA_W     = 32;
    localparam int STEPSZ_W   = 31;
    localparam int CNT_W      = 16;
    localparam int ESC_W      = 40;
    localparam int COORD_W    = 10;
    localparam int COLOR_W    = 8;
    localparam int PROD_W     = 64;
    localparam int MUL_W      = DATA_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;
    localparam int UPC_W      = 4;
    localparam int JT_W       = 3;
    localparam int MS_W       = 3;

    localparam int COLOR_MAX    = 255;
    localparam int COLOR_STEP   = 10;
    localparam int RED_PERIOD   = 10;
    localparam int GREEN_PERIOD = 20;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_RE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_IM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_SQ = 3'd5;

    localparam logic [DATA_W-1:0]   RST_ORIGIN_RE = 32'hFE00_0000;
    localparam logic [DATA_W-1:0]   RST_ORIGIN_IM = 32'h0100_0000;
    localparam logic [STEPSZ_W-1:0] RST_STEP_RE   = 31'd50332;
    localparam logic [STEPSZ_W-1:0] RST_STEP_IM   = 31'd33554;
    localparam logic [CNT_W-1:0]    RST_MAX_ITER  = 16'd2000;
    localparam logic [ESC_W-1:0]    RST_ESCAPE_SQ = 40'd268435456;

    localparam logic [JT_W-1:0] JT_NEXT     = 3'd0;
    localparam logic [JT_W-1:0] JT_WAIT_IN  = 3'd1;
    localparam logic [JT_W-1:0] JT_ZMAX     = 3'd2;
    localparam logic [JT_W-1:0] JT_TEST     = 3'd3;
    localparam logic [JT_W-1:0] JT_WAIT_OUT = 3'd4;
    localparam logic [JT_W-1:0] JT_GOTO     = 3'd5;

    localparam logic [MS_W-1:0] MS_CRE = 3'd0;
    localparam logic [MS_W-1:0] MS_CIM = 3'd1;
    localparam logic [MS_W-1:0] MS_RR  = 3'd2;
    localparam logic [MS_W-1:0] MS_II  = 3'd3;
    localparam logic [MS_W-1:0] MS_RI  = 3'd4;

    localparam logic [UPC_W-1:0] UPC_IDLE  = 4'd0;
    localparam logic [UPC_W-1:0] UPC_C_RE  = 4'd1;
    localparam logic [UPC_W-1:0] UPC_C_IM  = 4'd2;
    localparam logic [UPC_W-1:0] UPC_SETUP = 4'd3;
    localparam logic [UPC_W-1:0] UPC_DIFF  = 4'd4;
    localparam logic [UPC_W-1:0] UPC_Z     = 4'd5;
    localparam logic [UPC_W-1:0] UPC_M_RR  = 4'd6;
    localparam logic [UPC_W-1:0] UPC_M_II  = 4'd7;
    localparam logic [UPC_W-1:0] UPC_M_RI  = 4'd8;
    localparam logic [UPC_W-1:0] UPC_TEST  = 4'd9;
    localparam logic [UPC_W-1:0] UPC_FIN   = 4'd10;

    typedef struct packed {
        logic [DATA_W-1:0]   origin_re;
        logic [DATA_W-1:0]   origin_im;
        logic [STEPSZ_W-1:0] step_re;
        logic [STEPSZ_W-1:0] step_im;
        logic [CNT_W-1:0]    max_iter;
        logic [ESC_W-1:0]    escape_sq;
    } t_cfg;

    typedef struct packed {
        logic [MS_W-1:0]  mul_sel;
        logic             ld_cre;
        logic             ld_cim;
        logic             clr_z;
        logic             ld_diff;
        logic             inc_n;
        logic             ld_z;
        logic             ld_p1;
        logic             ld_p2;
        logic             ld_p3;
        logic             ld_esc;
        logic [JT_W-1:0]  jmp;
        logic [UPC_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic max_zero;
        logic escaped;
        logic at_limit;
    } t_flags;

    typedef struct packed {
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [CNT_W-1:0]   iterations;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
    } t_res;

    function automatic logic [DATA_W-1:0] sat32(input logic [PROD_W-1:0] v);
        logic [DATA_W-1:0] r;
        if ((&v[PROD_W-1:DATA_W-1]) || !(|v[PROD_W-1:DATA_W-1])) begin
            r = v[DATA_W-1:0];
        end else if (v[PROD_W-1]) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic t_ctrl ucode_rom(input logic [UPC_W-1:0] addr);
        t_ctrl w;
        w        = '0;
        w.mul_sel = MS_RR;
        w.jmp    = JT_NEXT;
        w.target = UPC_IDLE;
        case (addr)
            UPC_IDLE: begin
                w.jmp = JT_WAIT_IN;
            end
            UPC_C_RE: begin
                w.mul_sel = MS_CRE;
            end
            UPC_C_IM: begin
                w.ld_cre  = 1'b1;
                w.mul_sel = MS_CIM;
            end
            UPC_SETUP: begin
                w.ld_cim = 1'b1;
                w.clr_z  = 1'b1;
                w.jmp    = JT_ZMAX;
                w.target = UPC_FIN;
            end
            UPC_DIFF: begin
                w.ld_diff = 1'b1;
                w.inc_n   = 1'b1;
            end
            UPC_Z: begin
                w.ld_z = 1'b1;
            end
            UPC_M_RR: begin
                w.mul_sel = MS_RR;
            end
            UPC_M_II: begin
                w.ld_p1   = 1'b1;
                w.mul_sel = MS_II;
            end
            UPC_M_RI: begin
                w.ld_p2   = 1'b1;
                w.mul_sel = MS_RI;
            end
            UPC_TEST: begin
                w.ld_p3  = 1'b1;
                w.ld_esc = 1'b1;
                w.jmp    = JT_TEST;
                w.target = UPC_DIFF;
            end
            UPC_FIN: begin
                w.jmp    = JT_WAIT_OUT;
                w.target = UPC_IDLE;
            end
            default: begin
                w.jmp    = JT_GOTO;
                w.target = UPC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== sv/mep_if.sv =====
interface mep_pix_if import mep_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface mep_res_if import mep_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic [CNT_W-1:0]   iterations;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;

    modport source (output valid, output out_x, output out_y, output iterations,
                    output red, output green, input ready);
    modport sink (input valid, input out_x, input out_y, input iterations,
                  input red, input green, output ready);
endinterface

interface mep_cfg_if import mep_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/mandelbrot_escape_pixel.sv =====
// Mandelbrot escape-time unit for one pixel at a time. A pixel request is taken only while
// the unit is idle; it maps the coordinates to a point c in signed fixed point, iterates
// z = z*z + c from zero and returns the escape step with its color bytes, or zero when the
// iteration limit is reached first. A microcoded sequencer runs every iteration as six
// control steps through a single shared 33 by 33 bit multiplier. The result waits in an
// output register, and the next pixel request is taken as soon as the finished result has
// moved there.
module mandelbrot_escape_pixel import mep_pkg::*; #(
    parameter int MAX_SIDE  = 1024,
    parameter int FRAC_BITS = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mep_pix_if.sink   i_pix,
    mep_res_if.source o_res,
    mep_cfg_if.sink   i_cfg
);

    t_cfg   w_cfg;
    t_ctrl  w_ctrl;
    t_flags w_flags;
    t_res   w_res;
    logic   w_take;
    logic   w_out_free;
    logic   w_put;
    logic   r_out_valid;
    t_res   r_out;

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = (w_ctrl.jmp == JT_WAIT_IN);
    assign w_take      = i_pix.valid && i_pix.ready;
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_put       = (w_ctrl.jmp == JT_WAIT_OUT) && w_out_free;

    mep_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid && i_cfg.ready),
        .i_idx   (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (w_cfg)
    );

    mep_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_flags    (w_flags),
        .i_in_valid (i_pix.valid),
        .i_out_free (w_out_free),
        .o_ctrl     (w_ctrl)
    );

    mep_dpath #(
        .MAX_SIDE  (MAX_SIDE),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_cfg     (w_cfg),
        .i_ctrl    (w_ctrl),
        .i_take    (w_take),
        .i_pixel_x (i_pix.pixel_x),
        .i_pixel_y (i_pix.pixel_y),
        .o_flags   (w_flags),
        .o_res     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_put) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.out_x      = r_out.out_x;
    assign o_res.out_y      = r_out.out_y;
    assign o_res.iterations = r_out.iterations;
    assign o_res.red        = r_out.red;
    assign o_res.green      = r_out.green;

endmodule

// ===== sv/mep_cfg_regs.sv =====
module mep_cfg_regs import mep_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [CFG_IDX_W-1:0]  i_idx,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_re <= RST_ORIGIN_RE;
            r_cfg.origin_im <= RST_ORIGIN_IM;
            r_cfg.step_re   <= RST_STEP_RE;
            r_cfg.step_im   <= RST_STEP_IM;
            r_cfg.max_iter  <= RST_MAX_ITER;
            r_cfg.escape_sq <= RST_ESCAPE_SQ;
        end else if (i_wr) begin
            case (i_idx)
                REG_ORIGIN_RE: r_cfg.origin_re <= i_data[DATA_W-1:0];
                REG_ORIGIN_IM: r_cfg.origin_im <= i_data[DATA_W-1:0];
                REG_STEP_RE:   r_cfg.step_re   <= i_data[STEPSZ_W-1:0];
                REG_STEP_IM:   r_cfg.step_im   <= i_data[STEPSZ_W-1:0];
                REG_MAX_ITER:  r_cfg.max_iter  <= i_data[CNT_W-1:0];
                REG_ESCAPE_SQ: r_cfg.escape_sq <= i_data[ESC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/mep_useq.sv =====
module mep_useq import mep_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    input  logic   i_in_valid,
    input  logic   i_out_free,
    output t_ctrl  o_ctrl
);

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_ctrl            w_ctrl;
    logic [UPC_W-1:0] w_inc;

    assign w_ctrl = ucode_rom(r_upc);
    assign w_inc  = r_upc + UPC_W'(1);

    always_comb begin
        case (w_ctrl.jmp)
            JT_NEXT:     n_upc = w_inc;
            JT_WAIT_IN:  n_upc = i_in_valid ? w_inc : r_upc;
            JT_ZMAX:     n_upc = i_flags.max_zero ? w_ctrl.target : w_inc;
            JT_TEST:     n_upc = (i_flags.escaped || i_flags.at_limit) ? w_inc
                                                                       : w_ctrl.target;
            JT_WAIT_OUT: n_upc = i_out_free ? w_ctrl.target : r_upc;
            default:     n_upc = w_ctrl.target;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UPC_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctrl = w_ctrl;

endmodule

// ===== sv/mep_dpath.sv =====
module mep_dpath import mep_pkg::*; #(
    parameter int MAX_SIDE  = 1024,
    parameter int FRAC_BITS = 24
) (
    input  logic               i_clk,
    input  t_cfg               i_cfg,
    input  t_ctrl              i_ctrl,
    input  logic               i_take,
    input  logic [COORD_W-1:0] i_pixel_x,
    input  logic [COORD_W-1:0] i_pixel_y,
    output t_flags             o_flags,
    output t_res               o_res
);

    localparam int ESC_SH_W = ESC_W + FRAC_BITS;
    localparam int CMP_W    = ((ESC_SH_W > PROD_W) ? ESC_SH_W : PROD_W) + 1;

    logic [COORD_W-1:0]      r_x;
    logic [COORD_W-1:0]      r_y;
    logic signed [DATA_W-1:0] r_cre;
    logic signed [DATA_W-1:0] r_cim;
    logic signed [DATA_W-1:0] r_zr;
    logic signed [DATA_W-1:0] r_zi;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [PROD_W-1:0] r_p1;
    logic signed [PROD_W-1:0] r_p2;
    logic signed [PROD_W-1:0] r_p3;
    logic [CNT_W-1:0]        r_n;
    logic [3:0]              r_m10;
    logic [4:0]              r_m20;
    logic                    r_esc;

    logic [COORD_W-1:0]         w_x_cl;
    logic [COORD_W-1:0]         w_y_cl;
    logic signed [MUL_W-1:0]    w_op_a;
    logic signed [MUL_W-1:0]    w_op_b;
    logic signed [2*MUL_W-1:0]  w_prod;
    logic [PROD_W-1:0]          w_cre_sum;
    logic [PROD_W-1:0]          w_cim_sum;
    logic signed [PROD_W-1:0]   w_diff_sh;
    logic signed [PROD_W-1:0]   w_p3_sh;
    logic [PROD_W-1:0]          w_zr_sum;
    logic [PROD_W-1:0]          w_zi_sum;
    logic [CMP_W-1:0]           w_mag;
    logic [CMP_W-1:0]           w_esc;
    logic                       w_escaped;

    assign w_x_cl = (int'(i_pixel_x) >= MAX_SIDE) ? COORD_W'(MAX_SIDE - 1) : i_pixel_x;
    assign w_y_cl = (int'(i_pixel_y) >= MAX_SIDE) ? COORD_W'(MAX_SIDE - 1) : i_pixel_y;

    always_comb begin
        case (i_ctrl.mul_sel)
            MS_CRE: begin
                w_op_a = $signed({2'b00, i_cfg.step_re});
                w_op_b = $signed({{(MUL_W-COORD_W){1'b0}}, r_x});
            end
            MS_CIM: begin
                w_op_a = $signed({2'b00, i_cfg.step_im});
                w_op_b = $signed({{(MUL_W-COORD_W){1'b0}}, r_y});
            end
            MS_II: begin
                w_op_a = $signed({r_zi[DATA_W-1], r_zi});
                w_op_b = $signed({r_zi[DATA_W-1], r_zi});
            end
            MS_RI: begin
                w_op_a = $signed({r_zr[DATA_W-1], r_zr});
                w_op_b = $signed({r_zi[DATA_W-1], r_zi});
            end
            default: begin
                w_op_a = $signed({r_zr[DATA_W-1], r_zr});
                w_op_b = $signed({r_zr[DATA_W-1], r_zr});
            end
        endcase
    end

    assign w_prod = w_op_a * w_op_b;

    assign w_cre_sum = {{(PROD_W-DATA_W){i_cfg.origin_re[DATA_W-1]}}, i_cfg.origin_re}
                       + r_prod;
    assign w_cim_sum = {{(PROD_W-DATA_W){i_cfg.origin_im[DATA_W-1]}}, i_cfg.origin_im}
                       - r_prod;

    assign w_diff_sh = r_acc >>> FRAC_BITS;
    assign w_p3_sh   = r_p3 >>> (FRAC_BITS - 1);
    assign w_zr_sum  = w_diff_sh + {{(PROD_W-DATA_W){r_cre[DATA_W-1]}}, r_cre};
    assign w_zi_sum  = w_p3_sh + {{(PROD_W-DATA_W){r_cim[DATA_W-1]}}, r_cim};

    assign w_mag     = CMP_W'($unsigned(r_p1)) + CMP_W'($unsigned(r_p2));
    assign w_esc     = CMP_W'(i_cfg.escape_sq) << FRAC_BITS;
    assign w_escaped = w_mag > w_esc;

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_x <= w_x_cl;
            r_y <= w_y_cl;
        end
        r_prod <= w_prod[PROD_W-1:0];
        if (i_ctrl.ld_cre) begin
            r_cre <= sat32(w_cre_sum);
        end
        if (i_ctrl.ld_cim) begin
            r_cim <= sat32(w_cim_sum);
        end
        if (i_ctrl.ld_diff) begin
            r_acc <= r_p1 - r_p2;
        end
        if (i_ctrl.ld_z) begin
            r_zr <= sat32(w_zr_sum);
            r_zi <= sat32(w_zi_sum);
        end
        if (i_ctrl.clr_z) begin
            r_p1  <= '0;
            r_p2  <= '0;
            r_p3  <= '0;
            r_n   <= '0;
            r_m10 <= '0;
            r_m20 <= '0;
            r_esc <= 1'b0;
        end else begin
            if (i_ctrl.ld_p1) begin
                r_p1 <= r_prod;
            end
            if (i_ctrl.ld_p2) begin
                r_p2 <= r_prod;
            end
            if (i_ctrl.ld_p3) begin
                r_p3 <= r_prod;
            end
            if (i_ctrl.ld_esc) begin
                r_esc <= w_escaped;
            end
            if (i_ctrl.inc_n) begin
                r_n   <= r_n + CNT_W'(1);
                r_m10 <= (int'(r_m10) == RED_PERIOD - 1) ? '0 : r_m10 + 4'd1;
                r_m20 <= (int'(r_m20) == GREEN_PERIOD - 1) ? '0 : r_m20 + 5'd1;
            end
        end
    end

    assign o_flags.max_zero = (i_cfg.max_iter == '0);
    assign o_flags.escaped  = w_escaped;
    assign o_flags.at_limit = (r_n == i_cfg.max_iter);

    assign o_res.out_x      = r_x;
    assign o_res.out_y      = r_y;
    assign o_res.iterations = r_esc ? r_n : '0;
    assign o_res.red        = r_esc ? COLOR_W'(COLOR_MAX - COLOR_STEP * int'(r_m10)) : '0;
    assign o_res.green      = r_esc ? COLOR_W'(COLOR_MAX - COLOR_STEP * int'(r_m20)) : '0;

endmodule

// ===== sv/mep_checker.sv =====
module mep_checker import mep_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [CNT_W-1:0]   i_iterations,
    input logic [COLOR_W-1:0] i_red,
    input logic [COLOR_W-1:0] i_green
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before it was taken");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second pixel request taken while one is at work");

    a_inside_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_iterations == '0) |-> (i_red == '0) && (i_green == '0))
        else $error("inside pixel carries a color");

    a_escape_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_iterations != '0) |->
            (i_red >= COLOR_W'(COLOR_MAX - COLOR_STEP * (RED_PERIOD - 1))) &&
            (i_green >= COLOR_W'(COLOR_MAX - COLOR_STEP * (GREEN_PERIOD - 1))))
        else $error("escaped pixel color out of range");

endmodule

bind mandelbrot_escape_pixel mep_checker u_mep_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_pix.valid),
    .i_in_ready   (i_pix.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_iterations (o_res.iterations),
    .i_red        (o_res.red),
    .i_green      (o_res.green)
);
